/* hw/rtl/csbs_pkg.sv */
// ----------------------------------------------------------------------------
// csbs_pkg: shared types for the character sprite blitter
// Transaction codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package csbs_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SPRITE = 2'd1,
        ACT_SCROLL = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    localparam logic [7:0] TRANSPARENT_RESET = 8'h20;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // register the incoming transaction
        logic calc_row;     // window check and ring row
        logic calc_addr;    // image and background addresses
        logic wr_load;      // write character into both stores
        logic wr_img_char;  // write sprite character into image
        logic rd_back;      // read background for a transparent pixel
        logic wr_img_back;  // write background data into image
        logic rd_both;      // read both stores for a read transaction
        logic out_load;     // fill the output register
        logic scr_step;     // advance the ring offset
        logic scr_start;    // set up copy pointers
        logic copy_issue;   // one background read of the copy
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action action;
        logic    win;
        logic    alive;
        logic    transparent_hit;
        logic    out_busy;
        logic    copy_last;
    } t_status;

endpackage

`default_nettype wire

/* hw/rtl/character_sprite_blitter_scroll_unit.sv */
// ----------------------------------------------------------------------------
// character_sprite_blitter_scroll_unit: character sprite blitter, top level
// Loads, sprite pixels and reads step through capture, ring row, addresses
// and store access; a transparent pixel adds a write-back of the background
// read, and a read fills the output register from its response state, held there while the output is stalled.
// A scroll steps the ring offset, then runs the one-cell-a-cycle
// background-to-image copy through the background read port.
// One transaction at a time; the next is taken once the previous one retires.
// Reset (synchronous, active low): controller idle, ring offset zero,
// transparent code 0x20, output empty; both stores stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module character_sprite_blitter_scroll_unit #(
    parameter int ROWS = 55,
    parameter int COLS = 113
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_action,
    input  wire logic signed [8:0] i_row,
    input  wire logic signed [8:0] i_col,
    input  wire logic [7:0]        i_cell_char,
    input  wire logic              i_alive,
    // transparent code register
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_data,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [7:0]             o_image_char,
    output logic [7:0]             o_back_char,
    output logic                   o_in_window
);

    import csbs_pkg::*;

    // Command and status between sequencer and datapath.  The sequencer owns
    // all timing; the datapath only reacts to single-cycle strobes.
    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer: capture, ring row, addresses, then store access, or for a
    // scroll the ring step and copy.  A read transaction waits in its response
    // state until the output register is free, so no result is ever overwritten.
    csbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Datapath: background lives in ring order (physical row is logical row
    // minus offset, mod ROWS); the image is plain row-major.  A scroll walks
    // the background from the new ring start, wrapping at the end of store,
    // and writes each cell into the image in the cycle after its read.
    csbs_dpath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_cell_char  (i_cell_char),
        .i_alive      (i_alive),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_image_char (o_image_char),
        .o_back_char  (o_back_char),
        .o_in_window  (o_in_window)
    );

    // A taken transaction always blocks the next cycle: one in flight.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second transaction taken while one is in flight");

    // The output register is only refilled when its result has gone.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_valid && i_stall))
        else $error("pending result overwritten");

    // A new result appears only from a read transaction's response step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.out_load))
        else $error("result raised without a read");

    // Image stores never see two write sources at once.
    a_single_img_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.wr_load, w_cmd.wr_img_char, w_cmd.wr_img_back, w_cmd.copy_issue}))
        else $error("conflicting image writes");

endmodule

`default_nettype wire

/* hw/rtl/csbs_ram.sv */
// ----------------------------------------------------------------------------
// csbs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module csbs_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/csbs_ctrl.sv */
// ----------------------------------------------------------------------------
// csbs_ctrl: transaction sequencer
// One-hot state machine that steps each transaction through address
// calculation and store access or, for a scroll, the full-frame copy.
// ----------------------------------------------------------------------------
`default_nettype none

module csbs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire csbs_pkg::t_status i_status,
    output csbs_pkg::t_cmd         o_cmd
);

    import csbs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ROW    = 9'b000000010,
        S_ADDR   = 9'b000000100,
        S_EXEC   = 9'b000001000,
        S_WBACK  = 9'b000010000,
        S_RESP   = 9'b000100000,
        S_SCROLL = 9'b001000000,
        S_COPY   = 9'b010000000,
        S_DRAIN  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ROW;
                end
            end
            S_ROW: begin
                if (i_status.action == ACT_SCROLL) begin
                    o_cmd.scr_step = 1'b1;
                    n_state        = S_SCROLL;
                end else begin
                    o_cmd.calc_row = 1'b1;
                    n_state        = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.calc_addr = 1'b1;
                n_state         = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (i_status.action)
                    ACT_LOAD: begin
                        o_cmd.wr_load = i_status.win;
                    end
                    ACT_SPRITE: begin
                        if (i_status.alive && i_status.win) begin
                            if (i_status.transparent_hit) begin
                                o_cmd.rd_back = 1'b1;
                                n_state       = S_WBACK;
                            end else begin
                                o_cmd.wr_img_char = 1'b1;
                            end
                        end
                    end
                    ACT_READ: begin
                        o_cmd.rd_both = 1'b1;
                        n_state       = S_RESP;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_WBACK: begin
                o_cmd.wr_img_back = 1'b1;
                n_state           = S_IDLE;
            end
            S_RESP: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCROLL: begin
                o_cmd.scr_start = 1'b1;
                n_state         = S_COPY;
            end
            S_COPY: begin
                o_cmd.copy_issue = 1'b1;
                if (i_status.copy_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/csbs_dpath.sv */
// ----------------------------------------------------------------------------
// csbs_dpath: blitter datapath
// Transaction registers, address arithmetic, ring offset, copy pointers,
// the two character stores and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csbs_dpath #(
    parameter int ROWS = 55,
    parameter int COLS = 113
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire csbs_pkg::t_cmd    i_cmd,
    output csbs_pkg::t_status      o_status,
    input  wire logic [1:0]        i_action,
    input  wire logic signed [8:0] i_row,
    input  wire logic signed [8:0] i_col,
    input  wire logic [7:0]        i_cell_char,
    input  wire logic              i_alive,
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_data,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic [7:0]             o_image_char,
    output logic [7:0]             o_back_char,
    output logic                   o_in_window
);

    import csbs_pkg::*;

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int MW    = 17;

    // transaction registers
    t_action     r_action;
    logic [8:0]  r_row;
    logic [8:0]  r_col;
    logic [7:0]  r_char;
    logic        r_alive;
    logic        r_win;
    logic [RW-1:0] r_prow;
    logic [AW-1:0] r_img_addr;
    logic [AW-1:0] r_bk_addr;

    // control state
    logic [7:0]    r_transp;
    logic [RW-1:0] r_offset;
    logic [RW-1:0] n_offset;
    logic [AW-1:0] r_bk_ptr;
    logic [AW-1:0] r_cnt;
    logic          r_cp_wv;
    logic [AW-1:0] r_cp_waddr;
    logic          r_out_valid;

    logic [9:0]    w_ring;
    logic [9:0]    w_ring_wrap;
    logic          w_win;
    logic [RW-1:0] w_p0;
    logic [7:0]    w_img_q;
    logic [7:0]    w_bk_q;

    // store port muxing
    logic          w_bk_we;
    logic          w_bk_re;
    logic [AW-1:0] w_bk_raddr;
    logic          w_img_we;
    logic [AW-1:0] w_img_waddr;
    logic [7:0]    w_img_wdata;

    assign w_win = !r_row[8] && (r_row < 9'(ROWS)) && !r_col[8] && (r_col < 9'(COLS));

    // physical ring row; operands below 2*ROWS so one subtract wraps it
    assign w_ring      = {2'b00, r_row[7:0]} + 10'(ROWS) - 10'(r_offset);
    assign w_ring_wrap = (w_ring >= 10'(ROWS)) ? (w_ring - 10'(ROWS)) : w_ring;

    assign n_offset = (r_offset == RW'(ROWS - 1)) ? '0 : r_offset + 1'b1;
    assign w_p0     = (r_offset == '0) ? '0 : RW'(ROWS) - r_offset;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= t_action'(i_action);
            r_row    <= i_row;
            r_col    <= i_col;
            r_char   <= i_cell_char;
            r_alive  <= i_alive;
        end
        if (i_cmd.calc_row) begin
            r_win  <= w_win;
            r_prow <= w_ring_wrap[RW-1:0];
        end
        if (i_cmd.calc_addr) begin
            r_img_addr <= AW'(MW'(r_row[7:0]) * MW'(COLS) + MW'(r_col[7:0]));
            r_bk_addr  <= AW'(MW'(r_prow) * MW'(COLS) + MW'(r_col[7:0]));
        end
        r_cp_waddr <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transp    <= TRANSPARENT_RESET;
            r_offset    <= '0;
            r_bk_ptr    <= '0;
            r_cnt       <= '0;
            r_cp_wv     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_transp <= i_cfg_data;
            end
            if (i_cmd.scr_step) begin
                r_offset <= n_offset;
            end
            if (i_cmd.scr_start) begin
                r_bk_ptr <= AW'(MW'(w_p0) * MW'(COLS));
                r_cnt    <= '0;
            end else if (i_cmd.copy_issue) begin
                r_bk_ptr <= (r_bk_ptr == AW'(DEPTH - 1)) ? '0 : r_bk_ptr + 1'b1;
                r_cnt    <= (r_cnt == AW'(DEPTH - 1)) ? '0 : r_cnt + 1'b1;
            end
            r_cp_wv <= i_cmd.copy_issue;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register; payload held while stalled
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_image_char <= r_win ? w_img_q : 8'h00;
            o_back_char  <= r_win ? w_bk_q : 8'h00;
            o_in_window  <= r_win;
        end
    end

    assign o_valid = r_out_valid;

    assign w_bk_we    = i_cmd.wr_load;
    assign w_bk_re    = i_cmd.rd_back | i_cmd.rd_both | i_cmd.copy_issue;
    assign w_bk_raddr = i_cmd.copy_issue ? r_bk_ptr : r_bk_addr;

    always_comb begin
        w_img_we    = i_cmd.wr_load | i_cmd.wr_img_char | i_cmd.wr_img_back | r_cp_wv;
        w_img_waddr = r_img_addr;
        w_img_wdata = r_char;
        if (r_cp_wv) begin
            w_img_waddr = r_cp_waddr;
            w_img_wdata = w_bk_q;
        end else if (i_cmd.wr_img_back) begin
            w_img_wdata = w_bk_q;
        end
    end

    csbs_ram #(
        .W     (8),
        .DEPTH (DEPTH)
    ) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (w_bk_we),
        .i_waddr (r_bk_addr),
        .i_wdata (r_char),
        .i_re    (w_bk_re),
        .i_raddr (w_bk_raddr),
        .o_rdata (w_bk_q)
    );

    csbs_ram #(
        .W     (8),
        .DEPTH (DEPTH)
    ) u_image_ram (
        .i_clk   (i_clk),
        .i_we    (w_img_we),
        .i_waddr (w_img_waddr),
        .i_wdata (w_img_wdata),
        .i_re    (i_cmd.rd_both),
        .i_raddr (r_img_addr),
        .o_rdata (w_img_q)
    );

    always_comb begin
        o_status.action          = r_action;
        o_status.win             = r_win;
        o_status.alive           = r_alive;
        o_status.transparent_hit = (r_char == r_transp);
        o_status.out_busy        = r_out_valid && i_stall;
        o_status.copy_last       = (r_cnt == AW'(DEPTH - 1));
    end

endmodule

`default_nettype wire

/* sim/character_sprite_blitter_scroll_unit_tb.sv */
// ----------------------------------------------------------------------------
// character_sprite_blitter_scroll_unit_tb: self-checking bench for the blitter
// A short scripted part (window edges, dead and off-screen sprites, see-through
// pixels, a scroll) and four randomised phases, each with its own pacing and
// transparent code. Each read is checked against its scripted view or a local
// model of both stores; unwritten cells are kept unknown and never observed.
// ----------------------------------------------------------------------------

module character_sprite_blitter_scroll_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import csbs_pkg::*;

    localparam int ROWS          = 55;
    localparam int COLS          = 113;
    localparam int CELLS         = ROWS * COLS;
    // a scroll alone keeps both channels quiet for its whole frame copy
    localparam int QUIET_LIMIT   = 4 * (CELLS + 64);
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_OPS     = 200;

    // pacing modes
    localparam int PACE_FREE   = 0;
    localparam int PACE_SEND   = 1;
    localparam int PACE_RECV   = 2;
    localparam int PACE_BOTH   = 3;

    typedef struct packed {
        t_action           act;
        logic signed [8:0] row;
        logic signed [8:0] col;
        logic [7:0]        ch;
        logic              alive;
    } t_sprite_op;

    typedef struct packed {
        logic [7:0] image_char;
        logic [7:0] back_char;
        logic       in_window;
    } t_cell_view;

    // typed = 1: the expected view is written in the row, not predicted
    typedef struct packed {
        t_sprite_op op;
        logic       typed;
        t_cell_view view;
    } t_script_row;

    localparam t_script_row SCRIPT [25] = '{
        '{'{ACT_LOAD,   9'sd0,   9'sd0,   8'h00, 1'b0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        // read ignores char and alive
        '{'{ACT_READ,   9'sd0,   9'sd0,   8'hC3, 1'b1}, 1'b1, '{8'h00, 8'h00, 1'b1}},
        '{'{ACT_LOAD,   9'sd54,  9'sd112, 8'hFF, 1'b1}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,   9'sd54,  9'sd112, 8'h00, 1'b0}, 1'b1, '{8'hFF, 8'hFF, 1'b1}},
        // just past each edge and at the far ends of the field range
        '{'{ACT_READ,   9'sd55,  9'sd0,   8'h00, 1'b0}, 1'b1, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,   9'sd0,   9'sd113, 8'h00, 1'b0}, 1'b1, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,   9'h100,  9'h100,  8'hFF, 1'b1}, 1'b1, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,   9'sd255, 9'sd255, 8'h00, 1'b0}, 1'b1, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,  -9'sd1,   9'sd0,   8'h00, 1'b0}, 1'b1, '{8'h00, 8'h00, 1'b0}},
        // off-screen loads are dropped
        '{'{ACT_LOAD,   9'sd55,  9'sd0,   8'h77, 1'b0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_LOAD,  -9'sd1,  -9'sd1,   8'h77, 1'b0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_LOAD,   9'sd5,   9'sd7,   8'h41, 1'b0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        // opaque pixel
        '{'{ACT_SPRITE, 9'sd5,   9'sd7,   8'h5A, 1'b1}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,   9'sd5,   9'sd7,   8'h00, 1'b0}, 1'b1, '{8'h5A, 8'h41, 1'b1}},
        // dead sprite, then live pixels off either edge
        '{'{ACT_SPRITE, 9'sd5,   9'sd7,   8'h33, 1'b0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_SPRITE,-9'sd1,   9'sd7,   8'h33, 1'b1}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_SPRITE, 9'sd5,   9'sd113, 8'h33, 1'b1}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,   9'sd5,   9'sd7,   8'h00, 1'b0}, 1'b1, '{8'h5A, 8'h41, 1'b1}},
        // see-through pixel at the reset code restores the background
        '{'{ACT_SPRITE, 9'sd5,   9'sd7,   8'h20, 1'b1}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,   9'sd5,   9'sd7,   8'h00, 1'b0}, 1'b1, '{8'h41, 8'h41, 1'b1}},
        // scroll with junk in the fields it ignores; last row wraps to row zero
        '{'{ACT_SCROLL, 9'h1FF,  9'h155,  8'hAA, 1'b1}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,   9'sd6,   9'sd7,   8'h00, 1'b0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,   9'sd0,   9'sd112, 8'h00, 1'b0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_SPRITE, 9'sd6,   9'sd7,   8'h20, 1'b1}, 1'b0, '{8'h00, 8'h00, 1'b0}},
        '{'{ACT_READ,   9'sd6,   9'sd7,   8'hFF, 1'b0}, 1'b0, '{8'h00, 8'h00, 1'b0}}
    };

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic [1:0]        i_action    = ACT_LOAD;
    logic signed [8:0] i_row       = '0;
    logic signed [8:0] i_col       = '0;
    logic [7:0]        i_cell_char = '0;
    logic              i_alive     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [7:0]        i_cfg_data  = '0;
    logic              i_stall     = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [7:0]        o_image_char;
    logic [7:0]        o_back_char;
    logic              o_in_window;

    character_sprite_blitter_scroll_unit #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_cell_char  (i_cell_char),
        .i_alive      (i_alive),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_image_char (o_image_char),
        .o_back_char  (o_back_char),
        .o_in_window  (o_in_window)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Frame model: image indexed by logical cell, background by the
    // physical row behind the ring offset. Unwritten cells stay X.
    // ------------------------------------------------------------------
    logic [7:0] image_mem [CELLS];
    logic [7:0] back_mem  [CELLS];
    int         ring_ofs   = 0;
    logic [7:0] trans_code = TRANSPARENT_RESET;

    t_cell_view pending_views [$];

    int fails         = 0;
    int n_ops         = 0;
    int n_views       = 0;
    int n_scrolls     = 0;
    int n_see_through = 0;
    int quiet_cycles  = 0;
    int pace_mode     = PACE_BOTH;
    int last_row      = 0;
    int last_col      = 0;

    function automatic bit in_frame(int r, int c);
        return r >= 0 && r < ROWS && c >= 0 && c < COLS;
    endfunction

    function automatic int back_addr(int r, int c);
        return ((r + ROWS - ring_ofs) % ROWS) * COLS + c;
    endfunction

    // a read or see-through pixel on a cell not yet written becomes a load
    function automatic t_sprite_op guard_op(input t_sprite_op op);
        t_sprite_op g;
        int         r;
        int         c;
        g = op;
        r = op.row;
        c = op.col;
        if (in_frame(r, c)) begin
            if (op.act == ACT_READ && ($isunknown(image_mem[r * COLS + c]) ||
                                       $isunknown(back_mem[back_addr(r, c)])))
                g.act = ACT_LOAD;
            if (op.act == ACT_SPRITE && op.alive && op.ch == trans_code &&
                $isunknown(back_mem[back_addr(r, c)]))
                g.act = ACT_LOAD;
        end
        return g;
    endfunction

    // applies one accepted transaction to the model; reads yield a view
    task automatic apply_op(input t_sprite_op op, output bit has_view,
                            output t_cell_view view);
        int r;
        int c;
        bit win;
        r        = op.row;
        c        = op.col;
        win      = in_frame(r, c);
        has_view = 1'b0;
        view     = '0;
        case (op.act)
            ACT_LOAD: begin
                if (win) begin
                    back_mem[back_addr(r, c)] = op.ch;
                    image_mem[r * COLS + c]   = op.ch;
                end
            end
            ACT_SPRITE: begin
                if (win && op.alive) begin
                    if (op.ch == trans_code) begin
                        image_mem[r * COLS + c] = back_mem[back_addr(r, c)];
                        n_see_through++;
                    end else begin
                        image_mem[r * COLS + c] = op.ch;
                    end
                end
            end
            ACT_SCROLL: begin
                ring_ofs = (ring_ofs + 1) % ROWS;
                for (int i = 0; i < ROWS; i++)
                    for (int j = 0; j < COLS; j++)
                        image_mem[i * COLS + j] = back_mem[back_addr(i, j)];
                n_scrolls++;
            end
            default: begin
                has_view = 1'b1;
                if (win)
                    view = '{image_mem[r * COLS + c], back_mem[back_addr(r, c)], 1'b1};
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Pacing
    // ------------------------------------------------------------------
    function automatic bit sender_gap();
        if (pace_mode == PACE_SEND)
            return $urandom_range(99) < 75;
        if (pace_mode == PACE_BOTH)
            return $urandom_range(99) < 24;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (pace_mode == PACE_RECV)
            i_stall <= $urandom_range(99) < 75;
        else if (pace_mode == PACE_BOTH)
            i_stall <= $urandom_range(99) < 24;
        else
            i_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Driver: one transaction, predicted once it is taken.
    // ------------------------------------------------------------------
    task automatic issue(input t_sprite_op op, input bit typed, input t_cell_view typed_view);
        bit         has_view;
        t_cell_view view;
        op = guard_op(op);
        while (sender_gap()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= op.act;
        i_row       <= op.row;
        i_col       <= op.col;
        i_cell_char <= op.ch;
        i_alive     <= op.alive;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        apply_op(op, has_view, view);
        if (has_view)
            pending_views.push_back(typed ? typed_view : view);
        n_ops++;
    endtask

    // drain every pending read, then wait until the block is idle
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_views.size() != 0)
            @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_transparent(input logic [7:0] code);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= code;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        trans_code = code;
    endtask

    // Random transaction. Coordinates often repeat the previous one so that
    // pixels and reads land on freshly touched cells.
    function automatic t_sprite_op rand_op();
        t_sprite_op op;
        int         pick;
        int         r;
        int         c;
        pick   = $urandom_range(99);
        op.act = pick < 2  ? ACT_SCROLL :
                 pick < 35 ? ACT_LOAD   :
                 pick < 68 ? ACT_SPRITE : ACT_READ;
        pick = $urandom_range(99);
        if (pick < 35) begin
            r = last_row;
            c = last_col;
        end else if (pick < 75) begin
            r = $urandom_range(ROWS - 1);
            c = $urandom_range(COLS - 1);
        end else if (pick < 88) begin
            r = $urandom_range(1) ? ($urandom_range(1) ? -1 : ROWS)
                                  : ($urandom_range(1) ? 0 : ROWS - 1);
            c = $urandom_range(1) ? ($urandom_range(1) ? -1 : COLS)
                                  : ($urandom_range(1) ? 0 : COLS - 1);
        end else begin
            r = $urandom_range(511) - 256;
            c = $urandom_range(511) - 256;
        end
        last_row = r;
        last_col = c;
        op.row   = 9'(r);
        op.col   = 9'(c);
        op.ch    = (op.act == ACT_SPRITE && $urandom_range(99) < 30) ? trans_code
                                                                      : 8'($urandom);
        op.alive = $urandom_range(99) < 85;
        return op;
    endfunction

    // ------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cell_view got;
        t_cell_view want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_image_char, o_back_char, o_in_window};
                n_views++;
                if (pending_views.size() == 0) begin
                    fails++;
                    $error("result with nothing pending: image_char %0h back_char %0h in_window %0b",
                           got.image_char, got.back_char, got.in_window);
                end else begin
                    want = pending_views.pop_front();
                    if (got.image_char !== want.image_char) begin
                        fails++;
                        $error("image_char: expected %0h, got %0h",
                               want.image_char, got.image_char);
                    end
                    if (got.back_char !== want.back_char) begin
                        fails++;
                        $error("back_char: expected %0h, got %0h",
                               want.back_char, got.back_char);
                    end
                    if (got.in_window !== want.in_window) begin
                        fails++;
                        $error("in_window: expected %0b, got %0b",
                               want.in_window, got.in_window);
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL character_sprite_blitter_scroll_unit");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] code;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // scripted part at the reset transparent code
        pace_mode = PACE_FREE;
        foreach (SCRIPT[k])
            issue(SCRIPT[k].op, SCRIPT[k].typed, SCRIPT[k].view);

        // random phases; the code changes only while the block is idle
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            pace_mode = ph;
            code = ph == 0 ? 8'h00 : ph == 1 ? 8'hFF : ph == 2 ? 8'($urandom) : 8'h20;
            set_transparent(code);
            for (int i = 0; i < PHASE_OPS; i++) begin
                // hold off once per phase until every read has returned
                if (i == PHASE_OPS / 2)
                    settle();
                issue(rand_op(), 1'b0, '0);
            end
            // close on a read of a cell inside the window, or a load if that cell is unwritten
            issue('{ACT_READ, 9'($urandom_range(ROWS - 1)), 9'($urandom_range(COLS - 1)),
                    8'($urandom), 1'($urandom)}, 1'b0, '0);
        end
        settle();

        $display("Covered %0d transactions: scripted edges, then four pacing phases",
                 n_ops);
        $display("%0d reads checked, %0d scrolls, %0d see-through pixels drawn",
                 n_views, n_scrolls, n_see_through);
        if (fails == 0)
            $display("PASS character_sprite_blitter_scroll_unit");
        else
            $display("FAIL character_sprite_blitter_scroll_unit");
        $finish;
    end

endmodule
